/* rtl/core/mfp_timer_interrupt_unit_macros.svh */
// ----------------------------------------------------------------------------
// mfp timer interrupt unit assertion macros
// Shared assertion forms for the checker of the timer and interrupt block.
// ----------------------------------------------------------------------------
`ifndef MFP_TIMER_INTERRUPT_UNIT_MACROS_SVH
`define MFP_TIMER_INTERRUPT_UNIT_MACROS_SVH

// consequent holds in the same cycle
`define MFP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define MFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Constants, register indexes and small tables of the timer and interrupt block.
// ----------------------------------------------------------------------------
package mfp_pkg;

	localparam int TIME_WIDTH  = 48;
	localparam int RETRY_WIDTH = 16;
	localparam int BASE_W      = 64;
	localparam int DVD_W       = 72;
	localparam int DIV_STEPS   = DVD_W;
	localparam int DCNT_W      = $clog2(DIV_STEPS);
	localparam int REG_COUNT   = 24;

	localparam logic [23:0] REG_BASE   = 24'hFFFA01;
	localparam logic [7:0]  VR_RESET   = 8'h40;
	localparam logic [7:0]  VR_MASK    = 8'hF8;
	localparam logic [7:0]  VEC_HI     = 8'hF0;
	localparam logic [17:0] DELAY_MAX  = 18'h3FFFF;
	localparam logic [8:0]  RELOAD_FULL = 9'd256;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	localparam logic [4:0] REG_IERA  = 5'd3;
	localparam logic [4:0] REG_IERB  = 5'd4;
	localparam logic [4:0] REG_IPRA  = 5'd5;
	localparam logic [4:0] REG_IPRB  = 5'd6;
	localparam logic [4:0] REG_ISRA  = 5'd7;
	localparam logic [4:0] REG_ISRB  = 5'd8;
	localparam logic [4:0] REG_IMRA  = 5'd9;
	localparam logic [4:0] REG_IMRB  = 5'd10;
	localparam logic [4:0] REG_VR    = 5'd11;
	localparam logic [4:0] REG_TACR  = 5'd12;
	localparam logic [4:0] REG_TBCR  = 5'd13;
	localparam logic [4:0] REG_TCDCR = 5'd14;
	localparam logic [4:0] REG_TADR  = 5'd15;
	localparam logic [4:0] REG_TBDR  = 5'd16;
	localparam logic [4:0] REG_TCDR  = 5'd17;
	localparam logic [4:0] REG_TDDR  = 5'd18;

	function automatic logic [7:0] kfac(input logic [2:0] m);
		logic [7:0] k;
		unique case (m)
			3'd0: k = 8'd0;
			3'd1: k = 8'd4;
			3'd2: k = 8'd10;
			3'd3: k = 8'd16;
			3'd4: k = 8'd50;
			3'd5: k = 8'd64;
			3'd6: k = 8'd100;
			default: k = 8'd200;
		endcase
		return k;
	endfunction

	function automatic logic [11:0] kfac13(input logic [2:0] m);
		return 12'(kfac(m)) * 12'd13;
	endfunction

	function automatic logic [7:0] tvec(input logic [1:0] t);
		logic [7:0] v;
		unique case (t)
			2'd0: v = 8'd13;
			2'd1: v = 8'd8;
			2'd2: v = 8'd5;
			default: v = 8'd4;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] tbit(input logic [1:0] t);
		logic [7:0] b;
		unique case (t)
			2'd0: b = 8'd32;
			2'd1: b = 8'd1;
			2'd2: b = 8'd32;
			default: b = 8'd16;
		endcase
		return b;
	endfunction

	function automatic logic [8:0] expand(input logic [7:0] v);
		return (v != 8'd0) ? {1'b0, v} : RELOAD_FULL;
	endfunction

	function automatic logic [17:0] period_of(input logic [2:0] m, input logic [8:0] dr);
		logic [20:0] p;
		p = 21'(dr) * 21'(kfac13(m));
		return p[19:2];
	endfunction

endpackage

/* rtl/core/mfp_if.sv */
// ----------------------------------------------------------------------------
// mfp channel interfaces
// Request and result channels of the timer and interrupt block.
// ----------------------------------------------------------------------------
interface mfp_req_if import mfp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [1:0]            operation;
	logic [23:0]           address;
	logic [7:0]            write_data;
	logic [1:0]            timer_index;
	logic [TIME_WIDTH-1:0] cycle_count;

	modport source (output valid, operation, address, write_data, timer_index, cycle_count,
		input ready);
	modport sink (input valid, operation, address, write_data, timer_index, cycle_count,
		output ready);
endinterface

interface mfp_rsp_if;
	logic               valid;
	logic               ready;
	logic [7:0]         read_data;
	logic               released;
	logic signed [18:0] next_delay;
	logic [7:0]         ack_vector;
	logic               ack_valid;
	logic               irq_pending;

	modport source (output valid, read_data, released, next_delay, ack_vector, ack_valid,
		irq_pending, input ready);
	modport sink (input valid, read_data, released, next_delay, ack_vector, ack_valid,
		irq_pending, output ready);
endinterface

/* rtl/core/mfp_timer_interrupt_unit.sv */
// ----------------------------------------------------------------------------
// mfp_timer_interrupt_unit
// Register file, four lazy timers and the shared interrupt slot.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_item   in   operation, address, write_data, timer_index, cycle_count
// result    out  read_data, released, next_delay, ack_vector, ack_valid, irq_pending
//
// one transaction at a time; ready only while idle
// plain reads, writes and acks pass decode and finish; a tick also passes the
// retry state and, unless its timer is stopped, the expiry and delay states;
// a count read of a running timer makes two passes through the shared 72-step
// restoring divider; a control write makes none, one or two divider passes,
// and the c/d control write does this once per timer
// reset clears the control, timer and register state at once; a stalled result
// holds and the next transaction may be taken while it waits
// ----------------------------------------------------------------------------
module mfp_timer_interrupt_unit import mfp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	mfp_req_if.sink     in_item,
	mfp_rsp_if.source   result
);

	typedef enum logic [11:0] {
		S_IDLE       = 12'b000000000001,
		S_DECODE     = 12'b000000000010,
		S_MODE       = 12'b000000000100,
		S_MODE_DONE  = 12'b000000001000,
		S_SCALE_END  = 12'b000000010000,
		S_LIVE_MOD   = 12'b000000100000,
		S_LIVE_END   = 12'b000001000000,
		S_DIV        = 12'b000010000000,
		S_TICK_RETRY = 12'b000100000000,
		S_TICK_EXP   = 12'b001000000000,
		S_TICK_DLY   = 12'b010000000000,
		S_FINISH     = 12'b100000000000
	} state_t;

	state_t state_q, div_ret_q;

	logic [7:0]             regs_q   [REG_COUNT];
	logic [2:0]             mode_q   [4];
	logic [8:0]             reload_q [4];
	logic [8:0]             live_q   [4];
	logic [BASE_W-1:0]      base_q   [4];
	logic [17:0]            len_q    [4];
	logic [1:0]             em_q     [4];
	logic [RETRY_WIDTH-1:0] retry_q  [4];
	logic                   slot_q;
	logic [7:0]             slotvec_q;

	op_t               op_q;
	logic [4:0]        idx_q;
	logic              mapped_q;
	logic [7:0]        data_q;
	logic [BASE_W-1:0] now_q;
	logic [1:0]        t_q;
	logic [2:0]        nm_q;
	logic              second_q;
	logic              live_rd_q;

	logic [DVD_W-1:0]  dvd_q;
	logic [11:0]       dsr_q;
	logic [12:0]       prem_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [7:0]  rd_q;
	logic        rel_q;
	logic [18:0] nd_q;
	logic [7:0]  av_q;
	logic        ok_q;

	logic        out_valid_q;
	logic [7:0]  out_rd_q;
	logic        out_rel_q;
	logic [18:0] out_nd_q;
	logic [7:0]  out_av_q;
	logic        out_ok_q;
	logic        out_irq_q;

	logic [23:0]       in_off;
	logic              in_mapped;
	logic [4:0]        in_idx;
	logic [1:0]        in_t;
	logic              in_acc;

	logic [2:0]             cur_mode;
	logic [8:0]             cur_reload;
	logic [8:0]             cur_live;
	logic [BASE_W-1:0]      cur_base;
	logic [17:0]            cur_len;
	logic [RETRY_WIDTH-1:0] cur_retry;
	logic                   ie, im, sei;
	logic [BASE_W-1:0]      el_diff, el;
	logic [7:0]             vec_cur, tb, txdr, ipr_cur, isr_cur;
	logic [7:0]             ipr_req, isr_req;
	logic                   eoi_now, exp_now, is_tdr, rel_hit, is_tcr;
	logic [12:0]            trial;
	logic                   ge;
	logic [8:0]             live_new, rem_mode0;
	logic [8:0]             tick_reload;
	logic [17:0]            tick_len;
	logic [BASE_W-1:0]      d2;
	logic [18:0]            dly;

	assign in_acc    = in_item.valid && in_item.ready;
	assign in_off    = in_item.address - REG_BASE;
	assign in_mapped = in_item.address[0] && (in_item.address >= REG_BASE) &&
		(in_off[23:1] < 23'(REG_COUNT));
	assign in_idx    = in_off[5:1];

	always_comb begin
		priority if (op_t'(in_item.operation) == OP_TICK) in_t = in_item.timer_index;
		else if (in_idx == REG_TACR) in_t = 2'd0;
		else if (in_idx == REG_TBCR) in_t = 2'd1;
		else if (in_idx == REG_TCDCR) in_t = 2'd2;
		else in_t = in_idx[1:0] + 2'd1;
	end

	assign cur_mode   = mode_q[t_q];
	assign cur_reload = reload_q[t_q];
	assign cur_live   = live_q[t_q];
	assign cur_base   = base_q[t_q];
	assign cur_len    = len_q[t_q];
	assign cur_retry  = retry_q[t_q];
	assign ie         = em_q[t_q][0];
	assign im         = em_q[t_q][1];
	assign sei        = regs_q[REG_VR][3];

	assign el_diff = now_q - cur_base;
	assign el      = el_diff[BASE_W-1] ? '0 : el_diff;

	assign vec_cur = (regs_q[REG_VR] & VEC_HI) | tvec(t_q);
	assign tb      = tbit(t_q);
	assign ipr_cur = t_q[1] ? regs_q[REG_IPRB] : regs_q[REG_IPRA];
	assign isr_cur = t_q[1] ? regs_q[REG_ISRB] : regs_q[REG_ISRA];

	always_comb begin
		unique case (t_q)
			2'd0: txdr = regs_q[REG_TADR];
			2'd1: txdr = regs_q[REG_TBDR];
			2'd2: txdr = regs_q[REG_TCDR];
			default: txdr = regs_q[REG_TDDR];
		endcase
	end

	assign eoi_now = im && !slot_q && !sei;
	assign ipr_req = eoi_now ? (ipr_cur & ~tb) : (ipr_cur | tb);
	assign isr_req = eoi_now ? (isr_cur & ~tb) : ((im && sei) ? (isr_cur | tb) : isr_cur);

	assign exp_now     = !el_diff[BASE_W-1] && (el_diff >= BASE_W'(cur_len));
	assign tick_reload = expand(txdr);
	assign tick_len    = period_of(cur_mode, tick_reload);

	assign d2 = cur_base + BASE_W'(cur_len) - now_q;
	always_comb begin
		priority if (d2[BASE_W-1] || d2 == '0) dly = 19'd1;
		else if (d2 > BASE_W'(DELAY_MAX)) dly = {1'b0, DELAY_MAX};
		else dly = {1'b0, d2[17:0]};
	end

	assign is_tdr  = (idx_q >= REG_TADR) && (idx_q <= REG_TDDR);
	assign is_tcr  = (idx_q == REG_TACR) || (idx_q == REG_TBCR) || (idx_q == REG_TCDCR);
	assign rel_hit = (idx_q == REG_IERA) || (idx_q == REG_IERB) || (idx_q == REG_IMRA) ||
		(idx_q == REG_IMRB) || ((idx_q >= REG_TACR) && (idx_q <= REG_TDDR));

	assign trial     = {prem_q[11:0], dvd_q[DVD_W-1]};
	assign ge        = trial >= {1'b0, dsr_q};
	assign live_new  = cur_reload - prem_q[8:0];
	assign rem_mode0 = (cur_live > cur_reload) ? 9'd0 : (cur_reload - cur_live);

	assign in_item.ready      = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.read_data   = out_rd_q;
	assign result.released    = out_rel_q;
	assign result.next_delay  = out_nd_q;
	assign result.ack_vector  = out_av_q;
	assign result.ack_valid   = out_ok_q;
	assign result.irq_pending = out_irq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_ret_q   <= S_IDLE;
			out_valid_q <= 1'b0;
			slot_q      <= 1'b0;
			slotvec_q   <= 8'd0;
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= 8'd0;
			end
			regs_q[REG_VR] <= VR_RESET;
			for (int i = 0; i < 4; i++) begin
				mode_q[i]   <= 3'd0;
				reload_q[i] <= RELOAD_FULL;
				live_q[i]   <= RELOAD_FULL;
				base_q[i]   <= '0;
				len_q[i]    <= 18'd0;
				em_q[i]     <= 2'd0;
				retry_q[i]  <= '0;
			end
		end else begin
			if (out_valid_q && result.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q      <= op_t'(in_item.operation);
						idx_q     <= in_idx;
						mapped_q  <= in_mapped;
						data_q    <= in_item.write_data;
						now_q     <= BASE_W'(in_item.cycle_count);
						t_q       <= in_t;
						second_q  <= 1'b0;
						rd_q      <= 8'd0;
						rel_q     <= 1'b0;
						nd_q      <= 19'd0;
						av_q      <= 8'd0;
						ok_q      <= 1'b0;
						state_q   <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (op_q)
						OP_READ: begin
							if (mapped_q && is_tdr && cur_mode != 3'd0) begin
								dvd_q     <= DVD_W'({el, 2'b00});
								dsr_q     <= kfac13(cur_mode);
								prem_q    <= '0;
								dcnt_q    <= DCNT_W'(DIV_STEPS - 1);
								div_ret_q <= S_LIVE_MOD;
								live_rd_q <= 1'b1;
								state_q   <= S_DIV;
							end else begin
								if (mapped_q) begin
									rd_q <= is_tdr ? cur_live[7:0] : regs_q[idx_q];
								end
								state_q <= S_FINISH;
							end
						end
						OP_WRITE: begin
							if (mapped_q && is_tcr) begin
								state_q <= S_MODE;
							end else begin
								state_q <= S_FINISH;
							end
							if (mapped_q) begin
								rel_q <= rel_hit;
								unique case (idx_q)
									REG_IERA: begin
										em_q[0][0]     <= data_q[5];
										em_q[1][0]     <= data_q[0];
										regs_q[idx_q]  <= data_q;
									end
									REG_IERB: begin
										em_q[2][0]     <= data_q[5];
										em_q[3][0]     <= data_q[4];
										regs_q[idx_q]  <= data_q;
									end
									REG_IPRA, REG_IPRB: regs_q[idx_q] <= regs_q[idx_q] & data_q;
									REG_ISRA, REG_ISRB: begin
										if (sei) regs_q[idx_q] <= regs_q[idx_q] & data_q;
									end
									REG_IMRA: begin
										em_q[0][1]     <= data_q[5];
										em_q[1][1]     <= data_q[0];
										regs_q[idx_q]  <= data_q;
									end
									REG_IMRB: begin
										em_q[2][1]     <= data_q[5];
										em_q[3][1]     <= data_q[4];
										regs_q[idx_q]  <= data_q;
									end
									REG_VR: begin
										regs_q[REG_VR] <= data_q & VR_MASK;
										if (!data_q[3]) begin
											regs_q[REG_ISRA] <= 8'd0;
											regs_q[REG_ISRB] <= 8'd0;
										end
									end
									REG_TACR, REG_TBCR: begin
										nm_q    <= data_q[2:0];
									end
									REG_TCDCR: begin
										nm_q    <= data_q[6:4];
									end
									REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: begin
										regs_q[idx_q] <= data_q;
										if (cur_mode == 3'd0) begin
											reload_q[t_q] <= expand(data_q);
											live_q[t_q]   <= expand(data_q);
										end
									end
									default: regs_q[idx_q] <= data_q;
								endcase
							end
						end
						OP_TICK: state_q <= S_TICK_RETRY;
						default: begin
							if (slot_q) begin
								slot_q <= 1'b0;
								av_q   <= slotvec_q;
								ok_q   <= 1'b1;
							end
							state_q <= S_FINISH;
						end
					endcase
				end
				S_MODE: begin
					priority if (nm_q == 3'd0) begin
						if (cur_mode != 3'd0) begin
							dvd_q     <= DVD_W'({el, 2'b00});
							dsr_q     <= kfac13(cur_mode);
							prem_q    <= '0;
							dcnt_q    <= DCNT_W'(DIV_STEPS - 1);
							div_ret_q <= S_LIVE_MOD;
							live_rd_q <= 1'b0;
							state_q   <= S_DIV;
						end else begin
							len_q[t_q]  <= 18'd0;
							mode_q[t_q] <= 3'd0;
							state_q     <= S_MODE_DONE;
						end
					end else if (nm_q != cur_mode) begin
						len_q[t_q]  <= period_of(nm_q, cur_reload);
						mode_q[t_q] <= nm_q;
						if (cur_mode != 3'd0) begin
							dvd_q     <= DVD_W'(el) * DVD_W'(kfac(nm_q));
							dsr_q     <= 12'(kfac(cur_mode));
							prem_q    <= '0;
							dcnt_q    <= DCNT_W'(DIV_STEPS - 1);
							div_ret_q <= S_SCALE_END;
							state_q   <= S_DIV;
						end else begin
							base_q[t_q] <= now_q - BASE_W'(period_of(nm_q, rem_mode0));
							state_q     <= S_MODE_DONE;
						end
					end else begin
						state_q <= S_MODE_DONE;
					end
				end
				S_SCALE_END: begin
					base_q[t_q] <= now_q - dvd_q[BASE_W-1:0];
					state_q     <= S_MODE_DONE;
				end
				S_MODE_DONE: begin
					if (idx_q == REG_TCDCR && !second_q) begin
						second_q <= 1'b1;
						t_q      <= 2'd3;
						nm_q     <= data_q[2:0];
						state_q  <= S_MODE;
					end else begin
						regs_q[idx_q] <= data_q;
						state_q       <= S_FINISH;
					end
				end
				S_DIV: begin
					prem_q <= ge ? (trial - {1'b0, dsr_q}) : trial;
					dvd_q  <= {dvd_q[DVD_W-2:0], ge};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= div_ret_q;
					end
				end
				S_LIVE_MOD: begin
					dsr_q     <= {3'b000, cur_reload};
					prem_q    <= '0;
					dcnt_q    <= DCNT_W'(DIV_STEPS - 1);
					div_ret_q <= S_LIVE_END;
					state_q   <= S_DIV;
				end
				S_LIVE_END: begin
					live_q[t_q] <= live_new;
					if (live_rd_q) begin
						rd_q    <= live_new[7:0];
						state_q <= S_FINISH;
					end else begin
						len_q[t_q]  <= 18'd0;
						mode_q[t_q] <= 3'd0;
						state_q     <= S_MODE_DONE;
					end
				end
				S_TICK_RETRY: begin
					if (cur_retry != '0) begin
						if (!ie || !im) begin
							retry_q[t_q] <= '0;
						end else if (!slot_q) begin
							slot_q       <= 1'b1;
							slotvec_q    <= vec_cur;
							retry_q[t_q] <= cur_retry - 1'b1;
							if (cur_retry == RETRY_WIDTH'(1) && !sei) begin
								if (t_q[1]) begin
									regs_q[REG_IPRB] <= ipr_cur & ~tb;
									regs_q[REG_ISRB] <= isr_cur & ~tb;
								end else begin
									regs_q[REG_IPRA] <= ipr_cur & ~tb;
									regs_q[REG_ISRA] <= isr_cur & ~tb;
								end
							end
						end
					end
					if (cur_len == 18'd0) begin
						nd_q    <= '1;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_TICK_EXP;
					end
				end
				S_TICK_EXP: begin
					if (exp_now) begin
						if (ie) begin
							if (t_q[1]) begin
								regs_q[REG_IPRB] <= ipr_req;
								regs_q[REG_ISRB] <= isr_req;
							end else begin
								regs_q[REG_IPRA] <= ipr_req;
								regs_q[REG_ISRA] <= isr_req;
							end
							if (im) begin
								if (!slot_q) begin
									slot_q    <= 1'b1;
									slotvec_q <= vec_cur;
								end else if (cur_retry != '1) begin
									retry_q[t_q] <= cur_retry + 1'b1;
								end
							end
						end
						base_q[t_q]   <= cur_base + BASE_W'(cur_len);
						reload_q[t_q] <= tick_reload;
						len_q[t_q]    <= tick_len;
					end
					state_q <= S_TICK_DLY;
				end
				S_TICK_DLY: begin
					nd_q    <= dly;
					state_q <= S_FINISH;
				end
				default: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= rd_q;
						out_rel_q   <= rel_q;
						out_nd_q    <= nd_q;
						out_av_q    <= av_q;
						out_ok_q    <= ok_q;
						out_irq_q   <= slot_q;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/core/mfp_checker.sv */
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks of the timer and interrupt block, bound into mfp_timer_interrupt_unit.
// ----------------------------------------------------------------------------
`include "mfp_timer_interrupt_unit_macros.svh"

module mfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic        released,
	input logic [18:0] next_delay,
	input logic [7:0]  ack_vector,
	input logic        ack_valid,
	input logic        irq_pending
);

	`MFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result lost")
	`MFP_ASSERT_SAME(a_ack_clears, out_valid && ack_valid, !irq_pending, "ack left slot set")
	`MFP_ASSERT_SAME(a_ack_vec, out_valid && !ack_valid, ack_vector == 8'h00, "stray vector")
	`MFP_ASSERT_SAME(a_release, out_valid && released,
		read_data == 8'h00 && next_delay == 19'd0 && !ack_valid, "release mixed")
	`MFP_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready while busy")

endmodule

bind mfp_timer_interrupt_unit mfp_checker u_mfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_item.valid),
	.in_ready    (in_item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.read_data   (result.read_data),
	.released    (result.released),
	.next_delay  (result.next_delay),
	.ack_vector  (result.ack_vector),
	.ack_valid   (result.ack_valid),
	.irq_pending (result.irq_pending)
);

/* tb/mfp_timer_checker.sv */
// ----------------------------------------------------------------------------
// mfp timer checker
// Watches the request and result channels of the timer and interrupt block,
// predicts each result from its own copy of the register file, timers and
// interrupt slot, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module mfp_timer_checker import mfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mfp_req_if   req,
	mfp_rsp_if   rsp,
	output int   errors,
	output int   outstanding,
	output int   expiries,
	output int   grants
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  rd;
		logic        rel;
		logic [18:0] nd;
		logic [7:0]  av;
		logic        ok;
		logic        irq;
	} result_t;

	localparam logic [7:0]  PRESCALE [8] = '{8'd0, 8'd4, 8'd10, 8'd16, 8'd50, 8'd64, 8'd100, 8'd200};
	localparam logic [7:0]  VEC_LO   [4] = '{8'd13, 8'd8, 8'd5, 8'd4};
	localparam logic [7:0]  SRC_BIT  [4] = '{8'd32, 8'd1, 8'd32, 8'd16};
	localparam logic [4:0]  PEND_REG [4] = '{REG_IPRA, REG_IPRA, REG_IPRB, REG_IPRB};
	localparam logic [4:0]  SERV_REG [4] = '{REG_ISRA, REG_ISRA, REG_ISRB, REG_ISRB};
	localparam logic [4:0]  DATA_REG [4] = '{REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR};
	localparam logic [RETRY_WIDTH-1:0] RETRY_SAT = '1;
	localparam logic [18:0] STOPPED      = '1;

	logic [7:0]  regs [REG_COUNT];
	logic [2:0]  mode [4];
	logic [8:0]  reload [4];
	logic [8:0]  cnt [4];
	logic [63:0] base [4];
	logic [17:0] plen [4];
	logic [1:0]  flags [4];
	logic [RETRY_WIDTH-1:0] retry [4];
	logic        slot_pend;
	logic [7:0]  slot_vec;

	result_t expected_results [$];

	function automatic void clear_model();
		foreach (regs[i]) regs[i] = 8'd0;
		regs[REG_VR] = VR_RESET;
		for (int t = 0; t < 4; t++) begin
			mode[t] = 3'd0;
			reload[t] = RELOAD_FULL;
			cnt[t] = RELOAD_FULL;
			base[t] = 64'd0;
			plen[t] = 18'd0;
			flags[t] = 2'd0;
			retry[t] = '0;
		end
		slot_pend = 1'b0;
		slot_vec = 8'd0;
	endfunction

	function automatic logic [8:0] widen(logic [7:0] v);
		return (v != 8'd0) ? {1'b0, v} : 9'd256;
	endfunction

	function automatic logic [17:0] span(logic [2:0] m, logic [8:0] dr);
		logic [63:0] p;
		p = 64'(dr) * 64'(PRESCALE[m]) * 64'd13;
		return 18'(p >> 2);
	endfunction

	function automatic logic [63:0] since(int t, logic [63:0] now);
		logic [63:0] d;
		d = now - base[t];
		return d[63] ? 64'd0 : d;
	endfunction

	function automatic logic [8:0] count_now(int t, logic [63:0] now);
		logic [63:0] dv, d, e;
		if (mode[t] != 3'd0) begin
			dv = 64'(PRESCALE[mode[t]]) * 64'd13;
			d = since(t, now);
			e = (d / dv) * 64'd4 + ((d % dv) * 64'd4) / dv;
			cnt[t] = reload[t] - 9'(e % 64'(reload[t]));
		end
		return cnt[t];
	endfunction

	function automatic void change_mode(int t, logic [2:0] nm, logic [63:0] now);
		logic [63:0] d, ko, kn, s;
		logic [8:0] rem;
		if (nm == 3'd0) begin
			void'(count_now(t, now));
			plen[t] = 18'd0;
			mode[t] = 3'd0;
		end else if (nm != mode[t]) begin
			plen[t] = span(nm, reload[t]);
			if (mode[t] != 3'd0) begin
				d = since(t, now);
				ko = 64'(PRESCALE[mode[t]]);
				kn = 64'(PRESCALE[nm]);
				s = (d / ko) * kn + ((d % ko) * kn) / ko;
				base[t] = now - s;
			end else begin
				rem = (cnt[t] > reload[t]) ? 9'd0 : reload[t] - cnt[t];
				base[t] = now - 64'(span(nm, rem));
			end
			mode[t] = nm;
		end
	endfunction

	function automatic void load_data(int t, logic [7:0] v);
		regs[DATA_REG[t]] = v;
		if (mode[t] == 3'd0) begin
			reload[t] = widen(v);
			cnt[t] = reload[t];
		end
	endfunction

	function automatic void eoi_clear(int t);
		regs[PEND_REG[t]] &= ~SRC_BIT[t];
		regs[SERV_REG[t]] &= ~SRC_BIT[t];
	endfunction

	function automatic void raise(int t);
		regs[PEND_REG[t]] |= SRC_BIT[t];
		if (flags[t][1] && regs[REG_VR][3])
			regs[SERV_REG[t]] |= SRC_BIT[t];
		if (flags[t][1]) begin
			if (!slot_pend) begin
				slot_pend = 1'b1;
				slot_vec = (regs[REG_VR] & VEC_HI) | VEC_LO[t];
				if (!regs[REG_VR][3])
					eoi_clear(t);
			end else if (retry[t] < RETRY_SAT) begin
				retry[t]++;
			end
		end
	endfunction

	function automatic void write_reg(logic [4:0] idx, logic [7:0] v, logic [63:0] now);
		case (idx)
			REG_IERA: begin
				flags[0][0] = v[5];
				flags[1][0] = v[0];
				regs[idx] = v;
			end
			REG_IERB: begin
				flags[2][0] = v[5];
				flags[3][0] = v[4];
				regs[idx] = v;
			end
			REG_IPRA, REG_IPRB: regs[idx] &= v;
			REG_ISRA, REG_ISRB: if (regs[REG_VR][3]) regs[idx] &= v;
			REG_IMRA: begin
				flags[0][1] = v[5];
				flags[1][1] = v[0];
				regs[idx] = v;
			end
			REG_IMRB: begin
				flags[2][1] = v[5];
				flags[3][1] = v[4];
				regs[idx] = v;
			end
			REG_VR: begin
				regs[REG_VR] = v & VR_MASK;
				if (!v[3]) begin
					regs[REG_ISRA] = 8'd0;
					regs[REG_ISRB] = 8'd0;
				end
			end
			REG_TACR: begin
				change_mode(0, v[2:0], now);
				regs[idx] = v;
			end
			REG_TBCR: begin
				change_mode(1, v[2:0], now);
				regs[idx] = v;
			end
			REG_TCDCR: begin
				change_mode(2, v[6:4], now);
				change_mode(3, v[2:0], now);
				regs[idx] = v;
			end
			REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: load_data(int'(idx - REG_TADR), v);
			default: regs[idx] = v;
		endcase
	endfunction

	function automatic logic [18:0] service(int t, logic [63:0] now);
		logic ie, im;
		logic [63:0] d;
		ie = flags[t][0];
		im = flags[t][1];
		if (retry[t] != '0) begin
			if (!ie || !im) begin
				retry[t] = '0;
			end else if (!slot_pend) begin
				slot_pend = 1'b1;
				slot_vec = (regs[REG_VR] & VEC_HI) | VEC_LO[t];
				retry[t]--;
				if (retry[t] == '0 && !regs[REG_VR][3])
					eoi_clear(t);
			end
		end
		if (plen[t] == 18'd0)
			return STOPPED;
		d = now - base[t];
		if (!d[63] && d >= 64'(plen[t])) begin
			if (ie)
				raise(t);
			expiries++;
			base[t] += 64'(plen[t]);
			reload[t] = widen(regs[DATA_REG[t]]);
			plen[t] = span(mode[t], reload[t]);
		end
		d = base[t] + 64'(plen[t]) - now;
		if (d[63] || d == 64'd0)
			return 19'd1;
		return (d > 64'(DELAY_MAX)) ? 19'(DELAY_MAX) : 19'(d);
	endfunction

	function automatic result_t model_item(op_t op, logic [23:0] addr, logic [7:0] data,
		logic [1:0] t, logic [TIME_WIDTH-1:0] cc);
		result_t r;
		logic [63:0] now;
		logic mapped;
		logic [4:0] idx;
		r = '0;
		now = 64'(cc);
		mapped = addr[0] && addr >= REG_BASE && ((addr - REG_BASE) >> 1) < REG_COUNT;
		idx = mapped ? 5'((addr - REG_BASE) >> 1) : 5'd0;
		case (op)
			OP_READ: if (mapped) begin
				if (idx >= REG_TADR && idx <= REG_TDDR)
					r.rd = 8'(count_now(int'(idx - REG_TADR), now));
				else
					r.rd = regs[idx];
			end
			OP_WRITE: if (mapped) begin
				write_reg(idx, data, now);
				r.rel = (idx == REG_IERA || idx == REG_IERB || idx == REG_IMRA ||
					idx == REG_IMRB || (idx >= REG_TACR && idx <= REG_TDDR));
			end
			OP_TICK: r.nd = service(int'(t), now);
			default: if (slot_pend) begin
				slot_pend = 1'b0;
				r.av = slot_vec;
				r.ok = 1'b1;
				grants++;
			end
		endcase
		r.irq = slot_pend;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want, got;
		if (!arst_n) begin
			clear_model();
			expected_results.delete();
			errors = 0;
			expiries = 0;
			grants = 0;
		end else begin
			if (req.valid && req.ready)
				expected_results.push_back(model_item(op_t'(req.operation), req.address,
					req.write_data, req.timer_index, req.cycle_count));
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.read_data, rsp.released, rsp.next_delay, rsp.ack_vector,
					rsp.ack_valid, rsp.irq_pending};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result transaction with nothing expected", $realtime);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch rd %h/%h rel %b/%b nd %h/%h av %h/%h ok %b/%b irq %b/%b",
								$realtime, want.rd, got.rd, want.rel, got.rel, want.nd, got.nd,
								want.av, got.av, want.ok, got.ok, want.irq, got.irq);
					end
				end
			end
		end
		outstanding = expected_results.size();
	end

endmodule

/* tb/tb_mfp_timer_interrupt_unit.sv */
// ----------------------------------------------------------------------------
// tb_mfp_timer_interrupt_unit
// Drives bus reads and writes, timer ticks and interrupt acknowledges into the
// timer and interrupt block with random gaps and result stalls, and reports
// the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_mfp_timer_interrupt_unit import mfp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 6000;
	localparam int ITEMS    = 820;
	localparam logic [7:0] SRC_BIT [4] = '{8'd32, 8'd1, 8'd32, 8'd16};
	localparam logic [4:0] EN_REG  [4] = '{REG_IERA, REG_IERA, REG_IERB, REG_IERB};
	localparam logic [4:0] MSK_REG [4] = '{REG_IMRA, REG_IMRA, REG_IMRB, REG_IMRB};
	localparam logic [4:0] CR_REG  [4] = '{REG_TACR, REG_TBCR, REG_TCDCR, REG_TCDCR};

	logic clk;
	logic arst_n;
	int errors, outstanding, expiries, grants;
	int sent, idle_cnt;
	int op_count [4];
	bit quiet, hold_req;
	logic [TIME_WIDTH-1:0] now_cc;

	mfp_req_if in_item ();
	mfp_rsp_if result ();

	mfp_timer_interrupt_unit dut (.clk(clk), .arst_n(arst_n), .in_item(in_item), .result(result));

	mfp_timer_checker checker_i (.clk(clk), .arst_n(arst_n), .req(in_item), .rsp(result),
		.errors(errors), .outstanding(outstanding), .expiries(expiries), .grants(grants));

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [23:0] reg_addr(logic [4:0] idx);
		return REG_BASE + 24'(idx) * 24'd2;
	endfunction

	function automatic logic [TIME_WIDTH-1:0] next_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			now_cc = TIME_WIDTH'({$urandom, $urandom});
		else if (r < 6)
			now_cc = now_cc - TIME_WIDTH'($urandom_range(0, 500));
		else
			now_cc = now_cc + TIME_WIDTH'($urandom_range(0, 1500));
		return now_cc;
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send(op_t op, logic [23:0] a, logic [7:0] d, logic [1:0] t,
		logic [TIME_WIDTH-1:0] c);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			in_item.valid = 1'b0;
			@(negedge clk);
		end
		in_item.valid = 1'b1;
		in_item.operation = op;
		in_item.address = a;
		in_item.write_data = d;
		in_item.timer_index = t;
		in_item.cycle_count = c;
		do @(posedge clk); while (!in_item.ready);
		sent++;
		op_count[op]++;
		@(negedge clk);
	endtask

	task automatic wr(logic [4:0] idx, logic [7:0] d);
		send(OP_WRITE, reg_addr(idx), d, 2'($urandom), now_cc);
	endtask

	task automatic timer_burst();
		int t, n, r;
		logic [2:0] m;
		logic [7:0] v;
		t = $urandom_range(0, 3);
		wr(REG_TADR + 5'(t), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 20)));
		wr(EN_REG[t], 8'($urandom) | (($urandom_range(0, 3) != 0) ? SRC_BIT[t] : 8'd0));
		wr(MSK_REG[t], 8'($urandom) | (($urandom_range(0, 3) != 0) ? SRC_BIT[t] : 8'd0));
		if ($urandom_range(0, 3) == 0)
			wr(REG_VR, 8'($urandom));
		m = ($urandom_range(0, 2) != 0) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
		v = 8'($urandom);
		if (t == 2)
			v[6:4] = m;
		else
			v[2:0] = m;
		wr(CR_REG[t], v);
		n = $urandom_range(2, 8);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				send(OP_TICK, 24'($urandom), 8'($urandom), 2'(t), next_time());
			else if (r < 8)
				send(OP_ACK, 24'($urandom), 8'($urandom), 2'($urandom), next_time());
			else
				send(OP_READ, reg_addr(5'($urandom_range(5, 18))), 8'($urandom), 2'(t),
					next_time());
		end
	endtask

	task automatic noise_item();
		logic [23:0] a;
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			a = reg_addr(5'($urandom_range(0, REG_COUNT - 1)));
		else if (r == 2)
			a = REG_BASE + 24'($urandom_range(0, 60)) - 24'd4;
		else
			a = 24'($urandom);
		send(op_t'($urandom_range(0, 3)), a, 8'($urandom), 2'($urandom), next_time());
	endtask

	initial begin
		arst_n = 1'b0;
		in_item.valid = 1'b0;
		in_item.operation = OP_READ;
		in_item.address = '0;
		in_item.write_data = '0;
		in_item.timer_index = '0;
		in_item.cycle_count = '0;
		result.ready = 1'b0;
		now_cc = '0;
		sent = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		foreach (op_count[i]) op_count[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		send(OP_ACK, 24'd0, 8'd0, 2'd0, 48'd0);
		wr(REG_VR, 8'hFF);
		wr(REG_IERA, 8'h21);
		wr(REG_IMRA, 8'h21);
		wr(REG_TADR, 8'h00);
		wr(REG_TADR, 8'h03);
		now_cc = 48'd1000;
		wr(REG_TACR, 8'h01);
		send(OP_READ, reg_addr(REG_TADR), 8'h00, 2'd0, 48'd1020);
		send(OP_TICK, 24'hFFFFFF, 8'hFF, 2'd0, 48'd1100);
		send(OP_TICK, 24'd0, 8'd0, 2'd1, 48'd1100);
		send(OP_ACK, 24'd0, 8'd0, 2'd3, 48'd1100);
		send(OP_ACK, 24'd0, 8'd0, 2'd3, 48'd1100);
		wr(REG_TCDCR, 8'h77);
		wr(REG_TDDR, 8'hFF);
		send(OP_READ, 24'hFFFA02, 8'd0, 2'd0, 48'd1200);
		send(OP_READ, 24'hFFFFFF, 8'd0, 2'd0, 48'd1200);
		send(OP_WRITE, 24'hFFFA31, 8'hAA, 2'd0, 48'd1200);
		send(OP_TICK, 24'd0, 8'd0, 2'd3, 48'hFFFF_FFFF_FFFF);
		send(OP_TICK, 24'd0, 8'd0, 2'd3, 48'd0);
		now_cc = 48'd2000;
		wr(REG_TACR, 8'h00);
		send(OP_READ, reg_addr(REG_TADR), 8'd0, 2'd0, 48'd2000);
		wr(REG_IPRA, 8'h00);
		wr(REG_ISRA, 8'hFF);
		wr(REG_VR, 8'h00);
		send(OP_READ, reg_addr(REG_IERB), 8'd0, 2'd2, 48'd2000);

		// random
		while (sent < ITEMS) begin
			if (sent >= 250 && sent < 260)
				hold_req = 1'b1;
			quiet = (sent >= 400 && sent < 520);
			if (sent >= 600 && sent < 612) begin
				in_item.valid = 1'b0;
				while (outstanding != 0) @(negedge clk);
			end
			if ($urandom_range(0, 9) < 7)
				timer_burst();
			else
				noise_item();
		end
		in_item.valid = 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d transactions: %0d reads, %0d writes, %0d ticks, %0d acks",
			sent, op_count[OP_READ], op_count[OP_WRITE], op_count[OP_TICK], op_count[OP_ACK]);
		$display("saw %0d timer expiries and %0d granted acknowledges", expiries, grants);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side stalls
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result.ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			result.ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 11);
		end
	end

	initial begin
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((in_item.valid && in_item.ready) || (result.valid && result.ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= WATCHDOG) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
